>>> rtl/core/psat_pkg.sv
// ----------------------------------------------------------------------------
// psat_pkg
// Shared widths, function codes and types for the polygon overlap block.
// ----------------------------------------------------------------------------
package psat_pkg;

    localparam int MAX_VERTS = 16;
    localparam int ADDR_W    = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);

    localparam int COORD_W = 24;   // Q16.8 coordinate
    localparam int SUM_W   = 25;   // coordinate plus centre, or edge component
    localparam int RAD_W   = 23;
    localparam int UNIT_W  = 16;   // Q1.15 unit normal component
    localparam int PROD_W  = 41;
    localparam int PROJ_W  = 42;
    localparam int GAP_W   = 48;
    localparam int MTV_W   = 23;

    localparam logic [1:0] FUNC_SET_CENTRE = 2'd0;
    localparam logic [1:0] FUNC_APPEND     = 2'd1;
    localparam logic [1:0] FUNC_RUN        = 2'd2;

    localparam logic signed [GAP_W-1:0] START_GAP = GAP_W'(longint'(99999) * 8388608);
    localparam logic [MTV_W-1:0]        MTV_MAX   = {MTV_W{1'b1}};
    localparam logic [UNIT_W-1:0]       UNIT_MAX  = 16'd32767;

    typedef struct packed {
        logic done;   // one-cycle pulse, normal ready
        logic zero;   // edge had zero length, skip it
    } t_norm_stat;

endpackage

>>> rtl/core/psat_norm.sv
// ----------------------------------------------------------------------------
// psat_norm
// Unit edge normal in Q1.15: squared length, bit-serial square root and two
// restoring dividers working side by side.
// ----------------------------------------------------------------------------
module psat_norm
    import psat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_ex,
    input  logic signed [SUM_W-1:0]  i_ey,
    output t_norm_stat               o_stat,
    output logic signed [UNIT_W-1:0] o_nx,
    output logic signed [UNIT_W-1:0] o_ny
);

    typedef enum logic [2:0] {
        N_IDLE, N_SQ, N_SUM, N_SQRT, N_DIV, N_OUT
    } t_nstate;

    t_nstate                  r_state;
    logic signed [SUM_W-1:0]  r_ex, r_ey;
    logic [49:0]              r_sqx, r_sqy;
    logic [63:0]              r_v, r_r, r_b;
    logic [4:0]               r_step;
    logic [31:0]              r_q;
    logic [31:0]              r_remx, r_remy;
    logic [15:0]              r_quox, r_quoy;
    t_norm_stat               r_stat;
    logic signed [UNIT_W-1:0] r_nx, r_ny;

    logic [50:0]        w_m2;
    logic [63:0]        w_t;
    logic [SUM_W-1:0]   w_aex, w_aey;
    logic [32:0]        w_tx, w_ty;
    logic [UNIT_W-1:0]  w_mx, w_my;

    assign w_m2  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_t   = r_r + r_b;
    assign w_aex = r_ex[SUM_W-1] ? SUM_W'(-r_ex) : r_ex;
    assign w_aey = r_ey[SUM_W-1] ? SUM_W'(-r_ey) : r_ey;
    assign w_tx  = {r_remx, 1'b0};
    assign w_ty  = {r_remy, 1'b0};
    assign w_mx  = (r_quoy > UNIT_MAX) ? UNIT_MAX : r_quoy;
    assign w_my  = (r_quox > UNIT_MAX) ? UNIT_MAX : r_quox;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_stat  <= '0;
        end else begin
            case (r_state)
                N_IDLE: begin
                    r_stat <= '0;
                    if (i_start) begin
                        r_ex    <= i_ex;
                        r_ey    <= i_ey;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_stat  <= '0;
                    r_sqx   <= r_ex * r_ex;
                    r_sqy   <= r_ey * r_ey;
                    r_state <= N_SUM;
                end
                N_SUM: begin
                    if (w_m2 == '0) begin
                        r_stat  <= '{done: 1'b1, zero: 1'b1};
                        r_state <= N_IDLE;
                    end else begin
                        r_stat  <= '0;
                        r_v     <= {w_m2[49:0], 14'b0};
                        r_r     <= '0;
                        r_b     <= 64'h4000_0000_0000_0000;
                        r_step  <= '0;
                        r_state <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    r_stat <= '0;
                    if (r_v >= w_t) begin
                        r_v <= r_v - w_t;
                        r_r <= (r_r >> 1) + r_b;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_b    <= r_b >> 2;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_state <= N_DIV;
                    end
                end
                N_DIV: begin
                    r_stat <= '0;
                    // first cycle loads the divisor and the scaled dividends
                    if (r_step == 5'd0 && r_b == '0) begin
                        r_q    <= r_r[31:0];
                        r_remx <= {1'b0, w_aex, 6'b0};
                        r_remy <= {1'b0, w_aey, 6'b0};
                        r_b    <= 64'd1;
                    end else begin
                        if (w_tx >= {1'b0, r_q}) begin
                            r_remx <= 32'(w_tx - {1'b0, r_q});
                            r_quox <= {r_quox[14:0], 1'b1};
                        end else begin
                            r_remx <= w_tx[31:0];
                            r_quox <= {r_quox[14:0], 1'b0};
                        end
                        if (w_ty >= {1'b0, r_q}) begin
                            r_remy <= 32'(w_ty - {1'b0, r_q});
                            r_quoy <= {r_quoy[14:0], 1'b1};
                        end else begin
                            r_remy <= w_ty[31:0];
                            r_quoy <= {r_quoy[14:0], 1'b0};
                        end
                        r_step <= r_step + 5'd1;
                        if (r_step == 5'd15) begin
                            r_state <= N_OUT;
                        end
                    end
                end
                N_OUT: begin
                    r_nx    <= r_ey[SUM_W-1] ? UNIT_W'(-w_mx) : w_mx;
                    r_ny    <= (!r_ex[SUM_W-1] && r_ex != '0) ? UNIT_W'(-w_my) : w_my;
                    r_stat  <= '{done: 1'b1, zero: 1'b0};
                    r_state <= N_IDLE;
                end
                default: begin
                    r_stat  <= '0;
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_stat = r_stat;
    assign o_nx   = r_nx;
    assign o_ny   = r_ny;

endmodule

>>> rtl/core/polygon_sat_overlap.sv
// ----------------------------------------------------------------------------
// polygon_sat_overlap
// Separating-axis overlap test of two convex polygons held in vertex RAMs.
// ----------------------------------------------------------------------------
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_func, i_poly_sel, i_coord_x, i_coord_y,
//          |         |         | i_bound_radius
//  output  | o_valid | i_stall | o_collide, o_mtv_x, o_mtv_y
//
//  Loads (centre, vertex) never raise o_stall. A full run item holds o_stall until
//  its result is written to the output register; a zero-length edge is skipped,
//  a separating axis ends the run early, and the serial root and dividers of the
//  normal unit and the single RAM read port pace each axis.
//  Reset is synchronous and clears counts, centres and radii; vertex RAMs are
//  not cleared. A result waits in the output register while i_stall.
// ----------------------------------------------------------------------------
module polygon_sat_overlap
    import psat_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_func,
    input  logic                      i_poly_sel,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic [RAD_W-1:0]          i_bound_radius,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_collide,
    output logic [MTV_W-1:0]          o_mtv_x,
    output logic [MTV_W-1:0]          o_mtv_y
);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vert;

    typedef enum logic [3:0] {
        S_IDLE, S_PRE_MUL, S_PRE_CMP, S_EDGE_RD0, S_EDGE_RD1, S_EDGE_SUB,
        S_NORM, S_PROJ, S_GAP, S_SCALE, S_SAT, S_RESULT
    } t_state;

    t_vert r_mem_f [MAX_VERTS];
    t_vert r_mem_s [MAX_VERTS];
    t_vert r_rd_f, r_rd_s;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt_f, r_cnt_s;
    t_vert               r_cen_f, r_cen_s;
    logic [RAD_W-1:0]    r_rad_f, r_rad_s;

    logic [49:0]         r_dx2, r_dy2;
    logic [45:0]         r_rr;

    logic                r_k_sec;
    logic [CNT_W-1:0]    r_k_i;
    t_vert               r_vi;
    logic signed [SUM_W-1:0] r_ex, r_ey;
    logic                r_norm_start;
    logic signed [UNIT_W-1:0] r_nx, r_ny;

    logic                r_iss_run, r_iss_sec;
    logic [CNT_W-1:0]    r_iss_idx;
    logic                r_p1v, r_p1sec, r_p1fst;
    logic                r_p2v, r_p2sec, r_p2fst;
    logic                r_p3v, r_p3sec, r_p3fst;
    logic signed [SUM_W-1:0]  r_px, r_py;
    logic signed [PROD_W-1:0] r_mx, r_my;
    logic signed [PROJ_W-1:0] r_min_a, r_max_a, r_min_b, r_max_b;

    logic signed [GAP_W-1:0]  r_best;
    logic signed [UNIT_W-1:0] r_bnx, r_bny;
    logic [62:0]         r_sx, r_sy;

    logic                r_res_collide;
    logic [MTV_W-1:0]    r_res_x, r_res_y;

    logic                r_o_valid, r_o_collide;
    logic [MTV_W-1:0]    r_o_mtv_x, r_o_mtv_y;

    t_norm_stat               w_nstat;
    logic signed [UNIT_W-1:0] w_nx, w_ny;

    logic                w_accept;
    logic                w_we_f, w_we_s;
    logic [ADDR_W-1:0]   w_wa, w_ra;
    logic [CNT_W-1:0]    w_k_cnt, w_k_next, w_j;
    logic                w_adv_done, w_adv_sec;
    logic [CNT_W-1:0]    w_adv_i;
    logic [CNT_W-1:0]    w_iss_next;
    t_vert               w_ed, w_pd, w_pc;
    logic signed [SUM_W-1:0]  w_dx, w_dy;
    logic [50:0]         w_d2;
    logic [RAD_W-1:0]    w_rmax;
    logic signed [PROJ_W-1:0] w_p;
    logic signed [GAP_W-1:0]  w_gap, w_abest;
    logic [14:0]         w_anx, w_any;
    logic [32:0]         w_shx, w_shy;

    psat_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_norm_start),
        .i_ex    (r_ex),
        .i_ey    (r_ey),
        .o_stat  (w_nstat),
        .o_nx    (w_nx),
        .o_ny    (w_ny)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    // vertex writes on append while room remains
    assign w_we_f = w_accept && i_func == FUNC_APPEND && !i_poly_sel && r_cnt_f < CNT_W'(MAX_VERTS);
    assign w_we_s = w_accept && i_func == FUNC_APPEND && i_poly_sel && r_cnt_s < CNT_W'(MAX_VERTS);
    assign w_wa   = i_poly_sel ? r_cnt_s[ADDR_W-1:0] : r_cnt_f[ADDR_W-1:0];

    assign w_k_cnt  = r_k_sec ? r_cnt_s : r_cnt_f;
    assign w_k_next = r_k_i + CNT_W'(1);
    assign w_j      = (w_k_next < w_k_cnt) ? w_k_next : '0;

    always_comb begin
        case (r_state)
            S_EDGE_RD1: w_ra = w_j[ADDR_W-1:0];
            S_PROJ:     w_ra = r_iss_idx[ADDR_W-1:0];
            default:    w_ra = r_k_i[ADDR_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_f) begin
            r_mem_f[w_wa] <= '{x: i_coord_x, y: i_coord_y};
        end
        if (w_we_s) begin
            r_mem_s[w_wa] <= '{x: i_coord_x, y: i_coord_y};
        end
        r_rd_f <= r_mem_f[w_ra];
        r_rd_s <= r_mem_s[w_ra];
    end

    // next axis
    always_comb begin
        w_adv_done = 1'b0;
        w_adv_sec  = r_k_sec;
        w_adv_i    = w_k_next;
        if (w_k_next >= w_k_cnt) begin
            w_adv_i = '0;
            if (r_k_sec) begin
                w_adv_done = 1'b1;
            end else begin
                w_adv_sec = 1'b1;
            end
        end
    end

    assign w_iss_next = r_iss_idx + CNT_W'(1);
    assign w_ed = r_k_sec ? r_rd_s : r_rd_f;
    assign w_pd = r_p1sec ? r_rd_s : r_rd_f;
    assign w_pc = r_p1sec ? r_cen_s : r_cen_f;

    assign w_dx   = SUM_W'(r_cen_s.x) - SUM_W'(r_cen_f.x);
    assign w_dy   = SUM_W'(r_cen_s.y) - SUM_W'(r_cen_f.y);
    assign w_d2   = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_rmax = (r_rad_f > r_rad_s) ? r_rad_f : r_rad_s;

    assign w_p     = PROJ_W'(r_mx) + PROJ_W'(r_my);
    assign w_gap   = (r_min_a < r_min_b) ? (GAP_W'(r_min_b) - GAP_W'(r_max_a))
                                         : (GAP_W'(r_min_a) - GAP_W'(r_max_b));
    assign w_abest = r_best[GAP_W-1] ? -r_best : r_best;
    assign w_anx   = r_bnx[UNIT_W-1] ? 15'(-r_bnx) : r_bnx[14:0];
    assign w_any   = r_bny[UNIT_W-1] ? 15'(-r_bny) : r_bny[14:0];
    assign w_shx   = r_sx[62:30];
    assign w_shy   = r_sy[62:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt_f      <= '0;
            r_cnt_s      <= '0;
            r_cen_f      <= '0;
            r_cen_s      <= '0;
            r_rad_f      <= '0;
            r_rad_s      <= '0;
            r_norm_start <= 1'b0;
            r_iss_run    <= 1'b0;
            r_p1v        <= 1'b0;
            r_p2v        <= 1'b0;
            r_p3v        <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_norm_start <= (r_state == S_EDGE_SUB);
            // a waiting result reloads the register from S_RESULT instead
            if (r_o_valid && !i_stall && r_state != S_RESULT) begin
                r_o_valid <= 1'b0;
            end

            // projection pipe: RAM read, add centre, multiply, reduce
            r_p1v   <= (r_state == S_PROJ) && r_iss_run;
            r_p1sec <= r_iss_sec;
            r_p1fst <= (r_iss_idx == '0);
            r_p2v   <= r_p1v;
            r_p2sec <= r_p1sec;
            r_p2fst <= r_p1fst;
            r_p3v   <= r_p2v;
            r_p3sec <= r_p2sec;
            r_p3fst <= r_p2fst;
            r_px    <= SUM_W'(w_pd.x) + SUM_W'(w_pc.x);
            r_py    <= SUM_W'(w_pd.y) + SUM_W'(w_pc.y);
            r_mx    <= r_px * r_nx;
            r_my    <= r_py * r_ny;
            if (r_p3v) begin
                if (!r_p3sec) begin
                    if (r_p3fst || w_p < r_min_a) r_min_a <= w_p;
                    if (r_p3fst || w_p > r_max_a) r_max_a <= w_p;
                end else begin
                    if (r_p3fst || w_p < r_min_b) r_min_b <= w_p;
                    if (r_p3fst || w_p > r_max_b) r_max_b <= w_p;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_func)
                            FUNC_SET_CENTRE: begin
                                if (i_poly_sel) begin
                                    r_cen_s <= '{x: i_coord_x, y: i_coord_y};
                                    r_rad_s <= i_bound_radius;
                                    r_cnt_s <= '0;
                                end else begin
                                    r_cen_f <= '{x: i_coord_x, y: i_coord_y};
                                    r_rad_f <= i_bound_radius;
                                    r_cnt_f <= '0;
                                end
                            end
                            FUNC_APPEND: begin
                                if (w_we_s) r_cnt_s <= r_cnt_s + CNT_W'(1);
                                if (w_we_f) r_cnt_f <= r_cnt_f + CNT_W'(1);
                            end
                            FUNC_RUN: begin
                                r_res_collide <= 1'b0;
                                r_res_x       <= '0;
                                r_res_y       <= '0;
                                if (r_cnt_f == '0 || r_cnt_s == '0) begin
                                    r_state <= S_RESULT;
                                end else begin
                                    r_state <= S_PRE_MUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PRE_MUL: begin
                    r_dx2   <= w_dx * w_dx;
                    r_dy2   <= w_dy * w_dy;
                    r_rr    <= w_rmax * w_rmax;
                    r_state <= S_PRE_CMP;
                end
                S_PRE_CMP: begin
                    r_k_sec <= 1'b0;
                    r_k_i   <= '0;
                    r_best  <= START_GAP;
                    r_bnx   <= '0;
                    r_bny   <= '0;
                    r_state <= (w_d2 < {5'b0, r_rr}) ? S_EDGE_RD0 : S_RESULT;
                end
                S_EDGE_RD0: r_state <= S_EDGE_RD1;
                S_EDGE_RD1: begin
                    r_vi    <= w_ed;
                    r_state <= S_EDGE_SUB;
                end
                S_EDGE_SUB: begin
                    r_ex         <= SUM_W'(w_ed.x) - SUM_W'(r_vi.x);
                    r_ey         <= SUM_W'(w_ed.y) - SUM_W'(r_vi.y);
                    r_state      <= S_NORM;
                end
                S_NORM: begin
                    if (w_nstat.done) begin
                        if (w_nstat.zero) begin
                            // skip degenerate edge
                            r_k_sec <= w_adv_sec;
                            r_k_i   <= w_adv_i;
                            r_state <= w_adv_done ? S_SCALE : S_EDGE_RD0;
                        end else begin
                            r_nx      <= w_nx;
                            r_ny      <= w_ny;
                            r_iss_run <= 1'b1;
                            r_iss_sec <= 1'b0;
                            r_iss_idx <= '0;
                            r_state   <= S_PROJ;
                        end
                    end
                end
                S_PROJ: begin
                    if (r_iss_run) begin
                        if (!r_iss_sec) begin
                            if (w_iss_next < r_cnt_f) begin
                                r_iss_idx <= w_iss_next;
                            end else begin
                                r_iss_sec <= 1'b1;
                                r_iss_idx <= '0;
                            end
                        end else if (w_iss_next < r_cnt_s) begin
                            r_iss_idx <= w_iss_next;
                        end else begin
                            r_iss_run <= 1'b0;
                        end
                    end else if (!r_p1v && !r_p2v && !r_p3v) begin
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    if (w_gap > 0) begin
                        r_state <= S_RESULT;
                    end else begin
                        if (-w_gap < w_abest) begin
                            r_best <= w_gap;
                            r_bnx  <= r_nx;
                            r_bny  <= r_ny;
                        end
                        r_k_sec <= w_adv_sec;
                        r_k_i   <= w_adv_i;
                        r_state <= w_adv_done ? S_SCALE : S_EDGE_RD0;
                    end
                end
                S_SCALE: begin
                    r_sx    <= w_anx * w_abest[46:0];
                    r_sy    <= w_any * w_abest[46:0];
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_res_x       <= (w_shx > {10'b0, MTV_MAX}) ? MTV_MAX : w_shx[MTV_W-1:0];
                    r_res_y       <= (w_shy > {10'b0, MTV_MAX}) ? MTV_MAX : w_shy[MTV_W-1:0];
                    r_res_collide <= (w_shx != '0) || (w_shy != '0);
                    r_state       <= S_RESULT;
                end
                S_RESULT: begin
                    // hold until the output register is free
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid   <= 1'b1;
                        r_o_collide <= r_res_collide;
                        r_o_mtv_x   <= r_res_x;
                        r_o_mtv_y   <= r_res_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid   = r_o_valid;
    assign o_collide = r_o_collide;
    assign o_mtv_x   = r_o_mtv_x;
    assign o_mtv_y   = r_o_mtv_y;

endmodule

>>> tb/tb_polygon_sat_overlap.sv
// ----------------------------------------------------------------------------
// tb_polygon_sat_overlap
// Drives polygon loads and run items into the overlap block and checks each
// result against a separating-axis predictor kept in step with every
// accepted item. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_polygon_sat_overlap;
    import psat_pkg::*;

    typedef struct packed {
        logic             collide;
        logic [MTV_W-1:0] mtv_x;
        logic [MTV_W-1:0] mtv_y;
    } t_overlap;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [1:0]                i_func = FUNC_SET_CENTRE;
    logic                      i_poly_sel = 1'b0;
    logic signed [COORD_W-1:0] i_coord_x = '0;
    logic signed [COORD_W-1:0] i_coord_y = '0;
    logic [RAD_W-1:0]          i_bound_radius = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic                      o_collide;
    logic [MTV_W-1:0]          o_mtv_x;
    logic [MTV_W-1:0]          o_mtv_y;

    polygon_sat_overlap dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    longint vx [2][MAX_VERTS];
    longint vy [2][MAX_VERTS];
    int     nverts [2];
    longint cx [2];
    longint cy [2];
    longint rad [2];

    t_overlap overlap_q[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       rx_enable = 1'b0;

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint clamp_unit(longint u);
        if (u > 32767) return 32767;
        if (u < -32767) return -32767;
        return u;
    endfunction

    function automatic logic [MTV_W-1:0] scale_mtv(longint n, longint g);
        longint unsigned an, ag, r;
        an = n < 0 ? -n : n;
        ag = g < 0 ? -g : g;
        r = (an * ag) >> 30;
        return r > MTV_MAX ? MTV_MAX : r[MTV_W-1:0];
    endfunction

    function automatic void project_poly(int p, longint nx, longint ny,
                                         output longint lo, output longint hi);
        longint pr;
        lo = 0;
        hi = 0;
        for (int i = 0; i < nverts[p]; i++) begin
            pr = (vx[p][i] + cx[p]) * nx + (vy[p][i] + cy[p]) * ny;
            if (i == 0 || pr < lo) lo = pr;
            if (i == 0 || pr > hi) hi = pr;
        end
    endfunction

    function automatic t_overlap sat_overlap();
        t_overlap res;
        longint dx, dy, rmax, best, bnx, bny, ex, ey, nx, ny, q, gap;
        longint lo_a, hi_a, lo_b, hi_b, abest;
        longint unsigned d2, m2;
        int p, i, j;
        res = '0;
        bnx = 0;
        bny = 0;
        if (nverts[0] == 0 || nverts[1] == 0) return res;
        dx = cx[1] - cx[0];
        dy = cy[1] - cy[0];
        d2 = dx * dx + dy * dy;
        rmax = rad[0] > rad[1] ? rad[0] : rad[1];
        if (!(d2 < rmax * rmax)) return res;
        best = longint'(99999) * 8388608;
        for (int k = 0; k < nverts[0] + nverts[1]; k++) begin
            p = k < nverts[0] ? 0 : 1;
            i = p ? k - nverts[0] : k;
            j = (i + 1 < nverts[p]) ? i + 1 : 0;
            ex = vx[p][j] - vx[p][i];
            ey = vy[p][j] - vy[p][i];
            m2 = ex * ex + ey * ey;
            if (m2 == 0) continue;
            q = int_sqrt(m2 << 14);
            nx = clamp_unit((ey * 4194304) / q);
            ny = clamp_unit((-ex * 4194304) / q);
            project_poly(0, nx, ny, lo_a, hi_a);
            project_poly(1, nx, ny, lo_b, hi_b);
            gap = (lo_a < lo_b) ? (lo_b - hi_a) : (lo_a - hi_b);
            if (gap > 0) return res;
            abest = best < 0 ? -best : best;
            if (-gap < abest) begin
                best = gap;
                bnx = nx;
                bny = ny;
            end
        end
        res.mtv_x = scale_mtv(bnx, best);
        res.mtv_y = scale_mtv(bny, best);
        res.collide = (res.mtv_x | res.mtv_y) != 0;
        return res;
    endfunction

    function automatic void apply_item(logic [1:0] f, logic sel, longint x, longint y,
                                       longint r);
        if (f == FUNC_SET_CENTRE) begin
            cx[sel] = x;
            cy[sel] = y;
            rad[sel] = r;
            nverts[sel] = 0;
        end else if (f == FUNC_APPEND) begin
            if (nverts[sel] < MAX_VERTS) begin
                vx[sel][nverts[sel]] = x;
                vy[sel][nverts[sel]] = y;
                nverts[sel]++;
            end
        end else if (f == FUNC_RUN) begin
            overlap_q = {overlap_q, sat_overlap()};
        end
    endfunction

    function automatic int gap_len();
        int d;
        d = $urandom_range(0, 99);
        if (d < 60) return 0;
        if (d < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(logic [1:0] f, logic sel, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic [RAD_W-1:0] r);
        i_valid <= 1'b1;
        i_func <= f;
        i_poly_sel <= sel;
        i_coord_x <= x;
        i_coord_y <= y;
        i_bound_radius <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_item(f, sel, x, y, r);
        repeat (gap_len()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (overlap_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Convex polygon around the origin: a scaled, randomly rotated regular-ish shape.
    task automatic load_polygon(logic sel, int nv, longint ccx, longint ccy, longint size,
                                longint r);
        real ang, base;
        send_item(FUNC_SET_CENTRE, sel, COORD_W'(ccx), COORD_W'(ccy), RAD_W'(r));
        base = $urandom_range(0, 628) / 100.0;
        for (int i = 0; i < nv; i++) begin
            ang = base + 6.2831853 * i / nv;
            send_item(FUNC_APPEND, sel, COORD_W'(longint'(size * $cos(ang))),
                      COORD_W'(longint'(size * $sin(ang))), 0);
        end
    endtask

    task automatic test_directed();
        // empty polygons, then a square against overlapping and touching triangles
        send_item(FUNC_RUN, 0, 0, 0, 0);
        send_item(FUNC_SET_CENTRE, 0, 0, 0, 23'h7FFFFF);
        send_item(FUNC_APPEND, 0, -256, -256, 0);
        send_item(FUNC_APPEND, 0, 256, -256, 0);
        send_item(FUNC_APPEND, 0, 256, 256, 0);
        send_item(FUNC_APPEND, 0, 256, 256, 0);   // zero-length edge
        send_item(FUNC_APPEND, 0, -256, 256, 0);
        send_item(FUNC_RUN, 0, 0, 0, 0);           // second polygon empty
        send_item(FUNC_SET_CENTRE, 1, 128, 64, 0);
        send_item(FUNC_APPEND, 1, -256, -256, 0);
        send_item(FUNC_APPEND, 1, 256, -256, 0);
        send_item(FUNC_APPEND, 1, 256, 256, 0);
        send_item(FUNC_RUN, 0, 0, 0, 0);
        send_item(FUNC_SET_CENTRE, 1, 512, 0, 23'h7FFFFF);   // touching
        send_item(FUNC_APPEND, 1, -256, -256, 0);
        send_item(FUNC_APPEND, 1, 256, 0, 0);
        send_item(FUNC_APPEND, 1, -256, 256, 0);
        send_item(FUNC_RUN, 0, 0, 0, 0);
        send_item(FUNC_UNUSED, 1, 24'h7FFFFF, 24'h800000, 0);
        send_item(FUNC_SET_CENTRE, 0, 24'h7FFFFF, 24'h800000, 0);  // prefilter fails
        send_item(FUNC_APPEND, 0, 24'h800000, 24'h7FFFFF, 0);
        send_item(FUNC_RUN, 1, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_full_list();
        send_item(FUNC_SET_CENTRE, 1, 0, 0, 23'h7FFFFF);
        for (int i = 0; i < MAX_VERTS + 2; i++)
            send_item(FUNC_APPEND, 1, COORD_W'($urandom_range(0, 24'hFFFFFF)),
                      COORD_W'($urandom()), 0);
        send_item(FUNC_RUN, 0, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_random();
        int d, nv;
        longint size;
        for (int n = 0; n < 1200; ) begin
            d = $urandom_range(0, 99);
            if (d < 80) begin
                // well-formed pair, mostly small, a few at full vertex count
                for (int s = 0; s < 2; s++) begin
                    nv = ($urandom_range(0, 9) == 0) ? MAX_VERTS : $urandom_range(3, 6);
                    size = ($urandom_range(0, 19) == 0) ? 2000000 : $urandom_range(64, 4000);
                    load_polygon(1'(s), nv, longint'($urandom_range(0, 6000)) - 3000,
                                 longint'($urandom_range(0, 6000)) - 3000, size,
                                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 23'h7FFFFF)
                                                           : 2 * size + 8000);
                    n += nv + 1;
                end
                send_item(FUNC_RUN, 1'($urandom()), COORD_W'($urandom()),
                          COORD_W'($urandom()), RAD_W'($urandom()));
                n++;
            end else begin
                // noise: raw fields, occasional run with whatever is loaded
                send_item(2'($urandom_range(0, 3)), 1'($urandom()), COORD_W'($urandom()),
                          COORD_W'($urandom()), RAD_W'($urandom()));
                n++;
            end
            if ($urandom_range(0, 199) == 0) drain_results();
        end
        drain_results();
    endtask

    // receiver stall pattern
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!rx_enable) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            stall_left <= gap_len();
            i_stall <= 1'b0;
        end
    end

    // check each accepted result
    always @(posedge i_clk) begin
        t_overlap got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_collide, o_mtv_x, o_mtv_y};
            if (overlap_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with none expected: %p", got);
            end else begin
                want = overlap_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected c=%0d x=%0d y=%0d got c=%0d x=%0d y=%0d",
                                 want.collide, want.mtv_x, want.mtv_y,
                                 got.collide, got.mtv_x, got.mtv_y);
                end
            end
        end
    end

    // watchdog: cycles with nothing accepted on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_polygon_sat_overlap failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int p = 0; p < 2; p++) begin
            nverts[p] = 0;
            cx[p] = 0;
            cy[p] = 0;
            rad[p] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_enable = 1'b1;
        test_directed();
        test_full_list();
        test_random();
        if (mismatches == 0 && overlap_q.size() == 0) begin
            $display("tb_polygon_sat_overlap passed");
        end else begin
            $display("tb_polygon_sat_overlap failed");
        end
        $finish;
    end

endmodule
